>>> rtl/wgvs_pkg.sv
// Package for the weighted group virtual-time scheduler.
// Holds the request and response word types and the action and status codes.
// No dependencies.
`default_nettype none
package wgvs_pkg;

   localparam int TICK_W = 20;
   localparam logic [TICK_W-1:0] TICK_RESET = 20'd1000;

   localparam logic ACT_ENQUEUE  = 1'b0;
   localparam logic ACT_SCHEDULE = 1'b1;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_DROPPED = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;

   typedef struct packed {
      logic        action;
      logic [11:0] proc_id;
      logic [5:0]  group_index;
      logic [9:0]  group_weight;
      logic [19:0] time_used;
      logic        requeue_running;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] picked_process;
      logic [5:0]  picked_group;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/weighted_group_vtime_scheduler_core.sv
// Weighted fair virtual-time group scheduler core, one processor.
// Depends on wgvs_pkg for the word types and codes.
// An enqueue to a valid group passes the check state and then the response state; one that
// activates its group first runs a scan for the mean virtual time and a division. A schedule's
// run time is set by the one-bit-a-cycle divider and the one-entry-a-cycle scan of the group memory.
// Throughput: one word at a time; busy stays high through the strobe cycle.
// Reset is synchronous; group entries read as zero until written, no clearing pass.
`default_nettype none
module weighted_group_vtime_scheduler_core #(
   parameter int GROUPS      = 64,
   parameter int STACK_DEPTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wgvs_pkg::req_type                req_word,
   output logic                             rsp_strobe,
   output wgvs_pkg::rsp_type                rsp_word,
   input  wire                              csr_write_en,
   input  wire  [wgvs_pkg::TICK_W-1:0]      csr_write_data
);

   localparam int GIDX_W = $clog2(GROUPS);
   localparam int QW     = $clog2(STACK_DEPTH + 1);
   localparam int SA_W   = $clog2(GROUPS * STACK_DEPTH);
   localparam int SUM_W  = 32 + GIDX_W;
   localparam int DVS_W  = (GIDX_W + 1 > 10) ? GIDX_W + 1 : 10;
   localparam int CNT_W  = $clog2(SUM_W + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_E_CHK   = 4'd1;
   localparam logic [3:0] S_C_LD    = 4'd2;
   localparam logic [3:0] S_C_DIV2  = 4'd3;
   localparam logic [3:0] S_C_UPD   = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_AVG_FIN = 4'd6;
   localparam logic [3:0] S_ACT_WR  = 4'd7;
   localparam logic [3:0] S_P_UPD   = 4'd8;
   localparam logic [3:0] S_P_STK   = 4'd9;
   localparam logic [3:0] S_LAG_WR  = 4'd10;
   localparam logic [3:0] S_DIV     = 4'd11;
   localparam logic [3:0] S_RESP    = 4'd12;

   // Scan purposes.
   localparam logic [1:0] SCAN_ACT  = 2'd0;
   localparam logic [1:0] SCAN_PICK = 2'd1;
   localparam logic [1:0] SCAN_LAG  = 2'd2;

   typedef struct packed {
      logic [31:0]   vt;
      logic [31:0]   lag;
      logic [31:0]   last;
      logic [31:0]   stamp;
      logic [9:0]    weight;
      logic [QW-1:0] queued;
   } ent_type;

   function automatic logic [SA_W-1:0] stk_addr(input logic [GIDX_W-1:0] g,
                                                 input logic [QW-1:0] q);
      stk_addr = SA_W'(SA_W'(g) * SA_W'(STACK_DEPTH) + SA_W'(q));
   endfunction

   function automatic logic [9:0] weight_eff(input logic [9:0] w);
      weight_eff = (w == 10'd0) ? 10'd1 : w;
   endfunction

   // Memories.
   ent_type     group_mem [GROUPS];
   logic [11:0] stack_mem [GROUPS * STACK_DEPTH];

   logic              g_we;
   logic [GIDX_W-1:0] g_wa, g_ra;
   ent_type           g_wd;
   ent_type           g_rq_ff;
   logic              g_rv_ff;
   ent_type           g_rd;
   logic              stk_we;
   logic [SA_W-1:0]   stk_wa, stk_ra;
   logic [11:0]       stk_wd;
   logic [11:0]       stk_q_ff;

   // Control and datapath registers.
   logic [3:0]              state_ff, state_in, ret_ff, ret_in;
   wgvs_pkg::req_type       req_ff, req_in;
   logic [1:0]              status_ff, status_in;
   ent_type                 cur_ff, cur_in;
   logic [GIDX_W-1:0]       cur_g_ff, cur_g_in;
   logic [31:0]             q1_ff, q1_in;
   logic [31:0]             avg_ff, avg_in;
   logic                    neg_ff, neg_in;
   logic                    act_pick_ff, act_pick_in;
   logic [1:0]              mode_ff, mode_in;
   logic                    skip_en_ff, skip_en_in;
   logic [GIDX_W:0]         scan_idx_ff, scan_idx_in;
   logic                    proc_vld_ff, proc_vld_in;
   logic [GIDX_W-1:0]       proc_idx_ff, proc_idx_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [GIDX_W:0]         n_ff, n_in;
   logic                    found_ff, found_in;
   logic [GIDX_W-1:0]       best_g_ff, best_g_in;
   ent_type                 best_ff, best_in;
   logic                    run_valid_ff, run_valid_in;
   logic [11:0]             run_proc_ff, run_proc_in;
   logic [GIDX_W-1:0]       run_grp_ff, run_grp_in;
   logic [31:0]             act_cnt_ff, act_cnt_in;
   logic [wgvs_pkg::TICK_W-1:0] tick_ff;
   logic [SUM_W-1:0]        dvd_ff, dvd_in;
   logic [DVS_W-1:0]        dvs_ff, dvs_in;
   logic [DVS_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [GROUPS-1:0]       gvalid_ff, gvalid_in;

   // Launch requests for the scan and the divider, applied at the end.
   logic             scan_go;
   logic [1:0]       scan_mode;
   logic             div_go;
   logic [SUM_W-1:0] div_dvd;
   logic [9:0]       div_w;
   logic [DVS_W-1:0] div_dvs;
   logic [3:0]       div_ret;

   // Scratch values.
   ent_type          e;
   logic [31:0]      diff;
   logic             better;
   logic [DVS_W:0]   rem_sh;
   logic [SUM_W-1:0] mag;
   logic [31:0]      qs;

   always_ff @(posedge clock) begin
      if (g_we) begin
         group_mem[g_wa] <= g_wd;
      end
      g_rq_ff <= group_mem[g_ra];
      g_rv_ff <= gvalid_ff[g_ra];
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stk_q_ff <= stack_mem[stk_ra];
   end

   // An entry that was never written reads as all zeros.
   assign g_rd = g_rv_ff ? g_rq_ff : '0;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      req_in      = req_ff;
      status_in   = status_ff;
      cur_in      = cur_ff;
      cur_g_in    = cur_g_ff;
      q1_in       = q1_ff;
      avg_in      = avg_ff;
      neg_in      = neg_ff;
      act_pick_in = act_pick_ff;
      mode_in     = mode_ff;
      skip_en_in  = skip_en_ff;
      scan_idx_in = scan_idx_ff;
      proc_vld_in = proc_vld_ff;
      proc_idx_in = proc_idx_ff;
      sum_in      = sum_ff;
      n_in        = n_ff;
      found_in    = found_ff;
      best_g_in   = best_g_ff;
      best_in     = best_ff;
      run_valid_in = run_valid_ff;
      run_proc_in = run_proc_ff;
      run_grp_in  = run_grp_ff;
      act_cnt_in  = act_cnt_ff;
      dvd_in      = dvd_ff;
      dvs_in      = dvs_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      gvalid_in   = gvalid_ff;

      g_we   = 1'b0;
      g_wa   = cur_g_ff;
      g_wd   = cur_ff;
      g_ra   = cur_g_ff;
      stk_we = 1'b0;
      stk_wa = '0;
      stk_wd = run_proc_ff;
      stk_ra = stk_addr(cur_g_ff, cur_ff.queued);

      scan_go   = 1'b0;
      scan_mode = SCAN_PICK;
      div_go    = 1'b0;
      div_dvd   = '0;
      div_w     = 10'd1;
      div_ret   = S_IDLE;

      e      = g_rd;
      diff   = '0;
      better = 1'b0;
      rem_sh = '0;
      mag    = '0;
      qs     = '0;

      unique case (state_ff)
         S_IDLE: begin
            g_ra = GIDX_W'(req_word.group_index);
            if (start) begin
               req_in    = req_word;
               status_in = wgvs_pkg::STAT_OK;
               if (req_word.action == wgvs_pkg::ACT_ENQUEUE) begin
                  cur_g_in = GIDX_W'(req_word.group_index);
                  if (32'(req_word.group_index) >= 32'(GROUPS)) begin
                     status_in = wgvs_pkg::STAT_DROPPED;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_E_CHK;
                  end
               end else begin
                  run_valid_in = 1'b0;
                  if (run_valid_ff) begin
                     g_ra     = run_grp_ff;
                     cur_g_in = run_grp_ff;
                     state_in = S_C_LD;
                  end else begin
                     scan_go = 1'b1;
                  end
               end
            end
         end

         S_E_CHK: begin
            if (e.queued >= QW'(STACK_DEPTH)) begin
               status_in = wgvs_pkg::STAT_DROPPED;
               state_in  = S_RESP;
            end else begin
               stk_we   = 1'b1;
               stk_wa   = stk_addr(cur_g_ff, e.queued);
               stk_wd   = req_ff.proc_id;
               e.weight = req_ff.group_weight;
               e.queued = e.queued + QW'(1);
               g_we     = 1'b1;
               g_wd     = e;
               gvalid_in[cur_g_ff] = 1'b1;
               cur_in   = e;
               act_pick_in = 1'b0;
               if (e.queued == QW'(1)) begin
                  scan_go   = 1'b1;
                  scan_mode = SCAN_ACT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_C_LD: begin
            cur_in  = e;
            div_go  = 1'b1;
            div_dvd = SUM_W'(tick_ff);
            div_w   = weight_eff(e.weight);
            div_ret = S_C_DIV2;
         end

         S_C_DIV2: begin
            q1_in   = dvd_ff[31:0];
            div_go  = 1'b1;
            div_dvd = SUM_W'(req_ff.time_used);
            div_w   = weight_eff(cur_ff.weight);
            div_ret = S_C_UPD;
         end

         S_C_UPD: begin
            e     = cur_ff;
            diff  = q1_ff - dvd_ff[31:0];
            e.vt  = e.vt - diff;
            scan_go = 1'b1;
            if (req_ff.requeue_running) begin
               if (e.queued >= QW'(STACK_DEPTH)) begin
                  // The running process is lost; the pick still goes ahead.
                  status_in = wgvs_pkg::STAT_DROPPED;
               end else begin
                  stk_we   = 1'b1;
                  stk_wa   = stk_addr(cur_g_ff, e.queued);
                  e.queued = e.queued + QW'(1);
                  if (e.queued == QW'(1)) begin
                     scan_mode   = SCAN_ACT;
                     act_pick_in = 1'b1;
                  end
               end
            end
            g_we   = 1'b1;
            g_wd   = e;
            cur_in = e;
            gvalid_in[cur_g_ff] = 1'b1;
         end

         S_SCAN: begin
            g_ra = scan_idx_ff[GIDX_W-1:0];
            if (proc_vld_ff && e.queued != '0 &&
                !(skip_en_ff && proc_idx_ff == cur_g_ff)) begin
               sum_in = sum_ff + {{GIDX_W{e.vt[31]}}, e.vt};
               n_in   = n_ff + (GIDX_W+1)'(1);
               better = !found_ff || ($signed(e.vt) < $signed(best_ff.vt)) ||
                        (e.vt == best_ff.vt && e.stamp > best_ff.stamp);
               found_in = 1'b1;
               if (better) begin
                  best_in   = e;
                  best_g_in = proc_idx_ff;
               end
            end
            if (32'(scan_idx_ff) < 32'(GROUPS)) begin
               scan_idx_in = scan_idx_ff + (GIDX_W+1)'(1);
               proc_vld_in = 1'b1;
               proc_idx_in = scan_idx_ff[GIDX_W-1:0];
            end else begin
               proc_vld_in = 1'b0;
               if (!proc_vld_ff) begin
                  // All entries folded in; decide what the scan was for.
                  if (mode_ff == SCAN_PICK) begin
                     if (!found_ff) begin
                        status_in = wgvs_pkg::STAT_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        cur_in   = best_ff;
                        cur_g_in = best_g_ff;
                        div_go   = 1'b1;
                        div_dvd  = SUM_W'(tick_ff);
                        div_w    = weight_eff(best_ff.weight);
                        div_ret  = S_P_UPD;
                     end
                  end else begin
                     neg_in = sum_ff[SUM_W-1];
                     mag    = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
                     if (n_ff == '0) begin
                        dvd_in   = '0;
                        state_in = S_AVG_FIN;
                     end else begin
                        div_go  = 1'b1;
                        div_dvd = mag;
                        div_ret = S_AVG_FIN;
                     end
                  end
               end
            end
         end

         S_AVG_FIN: begin
            qs     = dvd_ff[31:0];
            avg_in = neg_ff ? -qs : qs;
            state_in = (mode_ff == SCAN_ACT) ? S_ACT_WR : S_LAG_WR;
         end

         S_ACT_WR: begin
            e = cur_ff;
            if ($signed(e.lag) > 0) begin
               e.vt = ($signed(e.last) > $signed(avg_ff)) ? e.last : avg_ff;
            end else if ($signed(e.lag) < 0) begin
               e.vt = avg_ff - e.lag;
            end else begin
               e.vt = avg_ff;
            end
            act_cnt_in = act_cnt_ff + 32'd1;
            e.stamp    = act_cnt_ff + 32'd1;
            g_we   = 1'b1;
            g_wd   = e;
            cur_in = e;
            if (act_pick_ff) begin
               scan_go = 1'b1;
            end else begin
               state_in = S_RESP;
            end
         end

         S_P_UPD: begin
            e        = cur_ff;
            e.vt     = e.vt + dvd_ff[31:0];
            e.queued = e.queued - QW'(1);
            stk_ra   = stk_addr(cur_g_ff, e.queued);
            g_we     = 1'b1;
            g_wd     = e;
            cur_in   = e;
            state_in = S_P_STK;
         end

         S_P_STK: begin
            run_proc_in  = stk_q_ff;
            run_grp_in   = cur_g_ff;
            run_valid_in = 1'b1;
            if (cur_ff.queued == '0) begin
               scan_go   = 1'b1;
               scan_mode = SCAN_LAG;
            end else begin
               state_in = S_RESP;
            end
         end

         S_LAG_WR: begin
            e      = cur_ff;
            e.lag  = avg_ff - e.vt;
            e.last = e.vt;
            g_we   = 1'b1;
            g_wd   = e;
            cur_in = e;
            state_in = S_RESP;
         end

         S_DIV: begin
            // Restoring division, one quotient bit a cycle.
            rem_sh = {rem_ff, dvd_ff[SUM_W-1]};
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = DVS_W'(rem_sh - {1'b0, dvs_ff});
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DVS_W-1:0];
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ret_ff;
            end
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      div_dvs = (mode_ff != SCAN_PICK && state_ff == S_SCAN) ? DVS_W'(n_ff) : DVS_W'(div_w);

      if (scan_go) begin
         state_in    = S_SCAN;
         mode_in     = scan_mode;
         skip_en_in  = (scan_mode == SCAN_ACT);
         scan_idx_in = '0;
         proc_vld_in = 1'b0;
         sum_in      = '0;
         n_in        = '0;
         found_in    = 1'b0;
      end
      if (div_go) begin
         state_in = S_DIV;
         ret_in   = div_ret;
         dvd_in   = div_dvd;
         dvs_in   = div_dvs;
         rem_in   = '0;
         cnt_in   = CNT_W'(SUM_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_valid_ff <= 1'b0;
         run_proc_ff  <= '0;
         run_grp_ff   <= '0;
         act_cnt_ff   <= '0;
         gvalid_ff    <= '0;
         tick_ff      <= wgvs_pkg::TICK_RESET;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         run_proc_ff  <= run_proc_in;
         run_grp_ff   <= run_grp_in;
         act_cnt_ff   <= act_cnt_in;
         gvalid_ff    <= gvalid_in;
         if (csr_write_en) begin
            tick_ff <= csr_write_data;
         end
      end
      ret_ff      <= ret_in;
      req_ff      <= req_in;
      status_ff   <= status_in;
      cur_ff      <= cur_in;
      cur_g_ff    <= cur_g_in;
      q1_ff       <= q1_in;
      avg_ff      <= avg_in;
      neg_ff      <= neg_in;
      act_pick_ff <= act_pick_in;
      mode_ff     <= mode_in;
      skip_en_ff  <= skip_en_in;
      scan_idx_ff <= scan_idx_in;
      proc_vld_ff <= proc_vld_in;
      proc_idx_ff <= proc_idx_in;
      sum_ff      <= sum_in;
      n_ff        <= n_in;
      found_ff    <= found_in;
      best_g_ff   <= best_g_in;
      best_ff     <= best_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
   end

   // The response word is shown for the single cycle spent in the response state.
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

   always_comb begin
      rsp_word.status = status_ff;
      if (req_ff.action == wgvs_pkg::ACT_SCHEDULE && status_ff != wgvs_pkg::STAT_EMPTY) begin
         rsp_word.picked_process = run_proc_ff;
         rsp_word.picked_group   = 6'(run_grp_ff);
      end else begin
         rsp_word.picked_process = '0;
         rsp_word.picked_group   = '0;
      end
   end

endmodule
`default_nettype wire

>>> dv/tb_weighted_group_vtime_scheduler_core.sv
// Self-checking testbench for weighted_group_vtime_scheduler_core.
// A directed table and then random words are checked against an in-bench model or fixed expected words.
// Depends on wgvs_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_weighted_group_vtime_scheduler_core;

   localparam int NGROUPS = 64;
   localparam int DEPTH   = 32;
   localparam int RANDOM_PER_PHASE = 420;
   localparam int DIR_ROWS = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   wgvs_pkg::req_type req_word = '0;
   logic rsp_strobe;
   wgvs_pkg::rsp_type rsp_word;
   logic csr_write_en = 1'b0;
   logic [wgvs_pkg::TICK_W-1:0] csr_write_data = '0;

   weighted_group_vtime_scheduler_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Scheduler model state, mirrored from the block.
   logic [19:0] tick_len;
   logic [31:0] vtime [NGROUPS];
   logic [31:0] lag [NGROUPS];
   logic [31:0] last_vtime [NGROUPS];
   logic [9:0]  weight [NGROUPS];
   int          queued [NGROUPS];
   logic [31:0] stamp [NGROUPS];
   logic [11:0] pstack [NGROUPS*DEPTH];
   logic [31:0] act_count;
   bit          run_valid;
   logic [11:0] run_pid;
   logic [5:0]  run_grp;

   wgvs_pkg::rsp_type pending_rsp [$];
   int error_count = 0;

   function automatic logic [31:0] eff_weight(int g);
      return (weight[g] == 0) ? 32'd1 : {22'd0, weight[g]};
   endfunction

   // Truncated mean of active group times, leaving out the group given by skip, if any.
   function automatic logic [31:0] mean_vtime(int skip);
      longint sum = 0;
      longint n = 0;
      for (int g = 0; g < NGROUPS; g++) begin
         if (g != skip && queued[g] != 0) begin
            sum += longint'($signed(vtime[g]));
            n++;
         end
      end
      if (n == 0) return 32'd0;
      return 32'(sum / n);
   endfunction

   function automatic bit push_pid(int g, logic [11:0] pid);
      logic [31:0] init;
      int q;
      q = queued[g];
      if (q >= DEPTH) return 1'b0;
      pstack[g*DEPTH + q] = pid;
      queued[g] = q + 1;
      if (q == 0) begin
         init = mean_vtime(g);
         if ($signed(lag[g]) > 0) begin
            if ($signed(last_vtime[g]) > $signed(init)) init = last_vtime[g];
         end else if ($signed(lag[g]) < 0) begin
            init = init - lag[g];
         end
         vtime[g] = init;
         act_count = act_count + 1;
         stamp[g] = act_count;
      end
      return 1'b1;
   endfunction

   // Applies one word to the model and returns the response it must produce.
   function automatic wgvs_pkg::rsp_type schedule_step(wgvs_pkg::req_type r);
      wgvs_pkg::rsp_type o;
      logic [31:0] w, diff;
      int best;
      int top;
      bit found;
      o = '0;
      best = 0;
      found = 1'b0;
      if (r.action == wgvs_pkg::ACT_ENQUEUE) begin
         if (queued[r.group_index] >= DEPTH) begin
            o.status = wgvs_pkg::STAT_DROPPED;
            return o;
         end
         weight[r.group_index] = r.group_weight;
         void'(push_pid(r.group_index, r.proc_id));
         return o;
      end
      if (run_valid) begin
         w = eff_weight(run_grp);
         diff = {12'd0, tick_len} / w - {12'd0, r.time_used} / w;
         vtime[run_grp] = vtime[run_grp] - diff;
         if (r.requeue_running && !push_pid(run_grp, run_pid)) begin
            o.status = wgvs_pkg::STAT_DROPPED;
         end
      end
      run_valid = 1'b0;
      for (int g = 0; g < NGROUPS; g++) begin
         if (queued[g] != 0) begin
            if (!found) begin
               best = g;
               found = 1'b1;
            end else if ($signed(vtime[g]) < $signed(vtime[best]) ||
                         (vtime[g] == vtime[best] && stamp[g] > stamp[best])) begin
               best = g;
            end
         end
      end
      if (!found) begin
         o.status = wgvs_pkg::STAT_EMPTY;
         return o;
      end
      vtime[best] = vtime[best] + {12'd0, tick_len} / eff_weight(best);
      top = queued[best] - 1;
      queued[best] = top;
      run_pid = pstack[best*DEPTH + top];
      run_grp = 6'(best);
      run_valid = 1'b1;
      if (top == 0) begin
         lag[best] = mean_vtime(NGROUPS) - vtime[best];
         last_vtime[best] = vtime[best];
      end
      o.picked_process = run_pid;
      o.picked_group = run_grp;
      return o;
   endfunction

   // Response checker: every strobe must match the oldest pending expectation.
   always @(posedge clock) begin
      wgvs_pkg::rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word %h", rsp_word);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_word.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.picked_process !== exp_rsp.picked_process) begin
               $error("picked_process: expected %0d, got %0d",
                      exp_rsp.picked_process, rsp_word.picked_process);
               error_count++;
            end
            if (rsp_word.picked_group !== exp_rsp.picked_group) begin
               $error("picked_group: expected %0d, got %0d",
                      exp_rsp.picked_group, rsp_word.picked_group);
               error_count++;
            end
         end
      end
   end

   // Presents one word and holds it until the core takes it. Start is left high,
   // so back-to-back words never drop and raise start within one step.
   task automatic send_word(wgvs_pkg::req_type w, bit fixed, wgvs_pkg::rsp_type fixed_rsp);
      wgvs_pkg::rsp_type model_rsp;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      model_rsp = schedule_step(w);
      pending_rsp.push_back(fixed ? fixed_rsp : model_rsp);
   endtask

   task automatic idle_gap(int gap_pct);
      int n;
      if ($urandom_range(99) < gap_pct) begin
         n = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drains all pending responses, then writes the tick length while idle.
   task automatic write_tick(logic [19:0] value);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tick_len = value;
   endtask

   function automatic wgvs_pkg::req_type make_word(int span, int enq_pct);
      wgvs_pkg::req_type r;
      int k;
      r.action = ($urandom_range(99) < enq_pct) ? wgvs_pkg::ACT_ENQUEUE :
                                                  wgvs_pkg::ACT_SCHEDULE;
      r.proc_id = 12'($urandom);
      r.group_index = 6'($urandom_range(span - 1));
      k = $urandom_range(15);
      r.group_weight = (k == 0) ? 10'd0 : (k == 1) ? 10'd1023 : (k < 6) ?
                       10'($urandom_range(1, 8)) : 10'($urandom_range(1, 1023));
      k = $urandom_range(15);
      r.time_used = (k == 0) ? 20'hFFFFF : (k == 1) ? 20'd0 : (k < 8) ?
                    20'($urandom_range(0, 2000)) : 20'($urandom);
      r.requeue_running = 1'($urandom);
      return r;
   endfunction

   wgvs_pkg::req_type dir_req [DIR_ROWS];
   bit                dir_fixed [DIR_ROWS];
   wgvs_pkg::rsp_type dir_rsp [DIR_ROWS];

   function automatic wgvs_pkg::req_type mk(logic act, int pid, int grp, int wt, int used,
                                            logic rq);
      wgvs_pkg::req_type r;
      r.action = act;
      r.proc_id = 12'(pid);
      r.group_index = 6'(grp);
      r.group_weight = 10'(wt);
      r.time_used = 20'(used);
      r.requeue_running = rq;
      return r;
   endfunction

   initial begin
      int span;
      int enq_pct;
      int gaps [4] = '{0, 46, 46, 35};
      logic [19:0] ticks [4];
      ticks = '{20'd1, 20'd1000000, wgvs_pkg::TICK_RESET, 20'($urandom_range(2, 999999))};

      tick_len = wgvs_pkg::TICK_RESET;
      for (int g = 0; g < NGROUPS; g++) begin
         vtime[g] = '0; lag[g] = '0; last_vtime[g] = '0;
         weight[g] = '0; queued[g] = 0; stamp[g] = '0;
      end
      act_count = '0;
      run_valid = 1'b0;
      run_pid = '0;
      run_grp = '0;

      // Directed rows; fixed expectations only where they are obvious.
      dir_req[0]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b1);
      dir_fixed[0] = 1; dir_rsp[0] = '{wgvs_pkg::STAT_EMPTY, 12'd0, 6'd0};
      dir_req[1]  = mk(wgvs_pkg::ACT_ENQUEUE, 4095, 63, 1023, 0, 1'b0);
      dir_fixed[1] = 1; dir_rsp[1] = '{wgvs_pkg::STAT_OK, 12'd0, 6'd0};
      dir_req[2]  = mk(wgvs_pkg::ACT_ENQUEUE, 0, 0, 0, 1048575, 1'b1);
      dir_fixed[2] = 1; dir_rsp[2] = '{wgvs_pkg::STAT_OK, 12'd0, 6'd0};
      dir_req[3]  = mk(wgvs_pkg::ACT_ENQUEUE, 1365, 0, 1, 0, 1'b0);
      dir_fixed[3] = 1; dir_rsp[3] = '{wgvs_pkg::STAT_OK, 12'd0, 6'd0};
      dir_req[4]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b1);
      dir_req[5]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 1048575, 1'b0);
      dir_req[6]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 1000000, 1'b1);
      dir_req[7]  = mk(wgvs_pkg::ACT_ENQUEUE, 2730, 42, 512, 0, 1'b0);
      dir_req[8]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 500, 1'b0);
      dir_req[9]  = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b0);
      dir_req[10] = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b0);
      dir_req[11] = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b0);
      dir_req[12] = mk(wgvs_pkg::ACT_ENQUEUE, 7, 21, 3, 0, 1'b0);
      dir_req[13] = mk(wgvs_pkg::ACT_ENQUEUE, 8, 22, 3, 0, 1'b0);
      dir_req[14] = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 0, 1'b1);
      dir_req[15] = mk(wgvs_pkg::ACT_SCHEDULE, 0, 0, 0, 3000, 1'b1);
      for (int i = 4; i < DIR_ROWS; i++) dir_fixed[i] = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_word(dir_req[i], dir_fixed[i], dir_rsp[i]);
         idle_gap(35);
      end

      // Random phases, each at a new tick length, with a per-phase idling mix.
      for (int p = 0; p < 4; p++) begin
         write_tick(ticks[p]);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            // Every 60 words a burst picks at random either two to six crowded groups, which fill stacks
            // and exercise drops, or the full group range.
            if (i % 60 == 0) begin
               span = ($urandom_range(3) == 0) ? NGROUPS : $urandom_range(2, 6);
               enq_pct = ($urandom_range(2) == 0) ? 80 : 50;
            end
            send_word(make_word(span, enq_pct), 1'b0, '0);
            idle_gap(gaps[p]);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_weighted_group_vtime_scheduler_core: done, clean");
      end else begin
         $display("tb_weighted_group_vtime_scheduler_core: done, errors");
      end
      $finish;
   end

   // Watchdog: ends the run with errors if it has not finished.
   initial begin
      #60ms;
      $display("tb_weighted_group_vtime_scheduler_core: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
